@@ rtl/sha1_pkg.sv @@
// Shared types, constants and round functions for the SHA-1 stream hasher.
// No dependencies; compile first.

package sha1_pkg;

    typedef logic [31:0] word_t;
    typedef logic [4:0][31:0] chain_t;

    // Byte position inside the 64-byte block
    localparam logic [5:0] POS_LAST = 6'd63;
    localparam logic [5:0] POS_LEN  = 6'd56;

    // Block shift register source select
    localparam logic [2:0] SH_NONE = 3'd0;
    localparam logic [2:0] SH_DATA = 3'd1;
    localparam logic [2:0] SH_MARK = 3'd2;
    localparam logic [2:0] SH_ZERO = 3'd3;
    localparam logic [2:0] SH_LEN  = 3'd4;

    // Round function groups (20 rounds each)
    localparam logic [1:0] PH_CH   = 2'd0;
    localparam logic [1:0] PH_PAR1 = 2'd1;
    localparam logic [1:0] PH_MAJ  = 2'd2;
    localparam logic [1:0] PH_PAR2 = 2'd3;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam chain_t CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    // Controller to datapath commands
    typedef struct packed {
        logic [2:0] shift;
        logic       comp_start;
        logic       round;
        logic [1:0] phase;
        logic       chain_add;
        logic       finish;
    } sha1_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_slot;
        logic len_slot;
    } sha1_sts_t;

    function automatic word_t sha1_k(input logic [1:0] phase);
        word_t k;
        case (phase)
            PH_CH:   k = 32'h5A827999;
            PH_PAR1: k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

    function automatic word_t sha1_f(input logic [1:0] phase, input word_t b,
                                     input word_t c, input word_t d);
        word_t f;
        case (phase)
            PH_CH:   f = (b & c) | (~b & d);
            PH_MAJ:  f = (b & c) | (b & d) | (c & d);
            default: f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

@@ rtl/sha1_if.sv @@
// Channel interfaces for the SHA-1 stream hasher: byte input and digest output.
// No dependencies.

interface sha1_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output has_byte, output is_last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

interface sha1_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, output digest_word4,
                    input ready);
    modport sink (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
endinterface

@@ rtl/sha1_dp.sv @@
// SHA-1 datapath: block/schedule shift register, round registers, chaining
// words, byte count and digest output register. Depends on sha1_pkg.

module sha1_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  sha1_pkg::sha1_cmd_t cmd,
    input  logic [7:0]          in_byte,
    output sha1_pkg::sha1_sts_t sts,
    output sha1_pkg::chain_t    digest
);
    import sha1_pkg::*;

    logic [5:0]  pos_reg;
    logic [60:0] total_reg;
    chain_t      chain_reg;
    chain_t      digest_reg;
    word_t       w_reg [16];
    word_t       v_reg [5];

    logic [7:0]  shift_byte;
    logic        byte_en;
    logic [63:0] bit_len;
    word_t       w_new;
    word_t       round_sum;

    // Byte source for the block shift register
    always_comb
    begin
        byte_en = 1'b1;
        case (cmd.shift)
            SH_DATA: shift_byte = in_byte;
            SH_MARK: shift_byte = PAD_MARK;
            SH_ZERO: shift_byte = 8'h00;
            default:
            begin
                shift_byte = 8'h00;
                byte_en    = 1'b0;
            end
        endcase
    end

    assign bit_len = {total_reg, 3'b000};

    // Next schedule word and round sum
    assign w_new = (w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
    assign round_sum = {v_reg[0][26:0], v_reg[0][31:27]}
                     + sha1_f(cmd.phase, v_reg[1], v_reg[2], v_reg[3])
                     + v_reg[4] + sha1_k(cmd.phase) + w_reg[0];

    assign sts.last_slot = (pos_reg == POS_LAST);
    assign sts.len_slot  = (pos_reg == POS_LEN);
    assign digest        = digest_reg;

    // Position, byte count, chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            total_reg <= '0;
            chain_reg <= CHAIN_INIT;
        end
        else
        begin
            if (byte_en)
                pos_reg <= pos_reg + 6'd1;
            else if (cmd.shift == SH_LEN || cmd.finish)
                pos_reg <= '0;
            if (cmd.finish)
                total_reg <= '0;
            else if (cmd.shift == SH_DATA)
                total_reg <= total_reg + 61'd1;
            if (cmd.finish)
                chain_reg <= CHAIN_INIT;
            else if (cmd.chain_add)
            begin
                for (int i = 0; i < 5; i++)
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
            end
        end
    end

    // Block store doubling as the rolling schedule window
    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], shift_byte};
        end
        else if (cmd.shift == SH_LEN)
        begin
            for (int i = 0; i < 14; i++)
                w_reg[i] <= w_reg[i+2];
            w_reg[14] <= bit_len[63:32];
            w_reg[15] <= bit_len[31:0];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= {w_new[30:0], w_new[31]};
        end
    end

    // Round variables a..e
    always_ff @(posedge clk)
    begin
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 5; i++)
                v_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            v_reg[0] <= round_sum;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= {v_reg[1][1:0], v_reg[1][31:2]};
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3];
        end
    end

    // Digest output register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            digest_reg <= chain_reg;
    end

endmodule

@@ rtl/sha1_ctrl.sv @@
// SHA-1 controller: input/output handshakes, padding sequence and round
// counter; drives sha1_dp through sha1_cmd_t. Depends on sha1_pkg.

module sha1_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_has,
    input  logic                in_last,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    input  sha1_pkg::sha1_sts_t sts,
    output sha1_pkg::sha1_cmd_t cmd
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_MARK  = 3'd3;
    localparam logic [2:0] S_ZERO  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [6:0] RND_PAR1 = 7'd20;
    localparam logic [6:0] RND_MAJ  = 7'd40;
    localparam logic [6:0] RND_PAR2 = 7'd60;
    localparam logic [6:0] RND_LAST = 7'd79;

    logic [2:0] state_reg, state_next;
    logic [2:0] post_reg, post_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        post_next  = post_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.shift  = SH_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_has)
                        cmd.shift = SH_DATA;
                    if (in_has && sts.last_slot)
                    begin
                        cmd.comp_start = 1'b1;
                        state_next     = S_ROUND;
                        post_next      = in_last ? S_MARK : S_IDLE;
                    end
                    else if (in_last)
                        state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.shift = SH_MARK;
                if (sts.last_slot)
                begin
                    cmd.comp_start = 1'b1;
                    state_next     = S_ROUND;
                    post_next      = S_ZERO;
                end
                else
                    state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (sts.len_slot)
                begin
                    cmd.shift      = SH_LEN;
                    cmd.comp_start = 1'b1;
                    state_next     = S_ROUND;
                    post_next      = S_DONE;
                end
                else
                begin
                    cmd.shift = SH_ZERO;
                    if (sts.last_slot)
                    begin
                        cmd.comp_start = 1'b1;
                        state_next     = S_ROUND;
                        post_next      = S_ZERO;
                    end
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (cnt_reg < RND_PAR1)
                    cmd.phase = PH_CH;
                else if (cnt_reg < RND_MAJ)
                    cmd.phase = PH_PAR1;
                else if (cnt_reg < RND_PAR2)
                    cmd.phase = PH_MAJ;
                else
                    cmd.phase = PH_PAR2;
                if (cnt_reg == RND_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_ADD;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_ADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = post_reg;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared on transfer
    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            post_reg      <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            post_reg      <= post_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/sha1_stream_hasher.sv @@
// SHA-1 over a byte stream, one byte per transfer; digest as five words.
// A byte that completes a 64-byte block starts a compression (load, 80
// rounds on one round unit, add); no input is taken until it ends. End of
// message: padding shifts one byte per cycle outside compressions; the digest
// is held in an output register, loaded once that register is free.
// Reset (rst_n, async low) loads the initial chaining words, clears the count.

module sha1_stream_hasher (
    input  logic                 clk,
    input  logic                 rst_n,
    sha1_byte_if.sink            msg,
    sha1_digest_if.source        digest
);
    import sha1_pkg::*;

    sha1_cmd_t cmd;
    sha1_sts_t sts;
    chain_t    digest_words;

    sha1_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg.valid),
        .in_has    (msg.has_byte),
        .in_last   (msg.is_last),
        .in_ready  (msg.ready),
        .out_ready (digest.ready),
        .out_valid (digest.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    sha1_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .in_byte (msg.data_byte),
        .sts     (sts),
        .digest  (digest_words)
    );

    assign digest.digest_word0 = digest_words[0];
    assign digest.digest_word1 = digest_words[1];
    assign digest.digest_word2 = digest_words[2];
    assign digest.digest_word3 = digest_words[3];
    assign digest.digest_word4 = digest_words[4];

endmodule

@@ tb/sv/sha1_digest_checker.sv @@
// Digest checker for the SHA-1 stream hasher: watches both channels, keeps its
// own SHA-1 state per message and compares every digest transfer in order.
// Depends on sha1_pkg (chain types, initial chain, pad marker) and sha1_if.sv.

module sha1_digest_checker (
    input  logic   clk,
    input  logic   rst_n,
    sha1_byte_if   msg,
    sha1_digest_if digest,
    output int     errors,
    output int     pending
);
    import sha1_pkg::*;

    localparam word_t K_CH   = 32'h5A827999;
    localparam word_t K_PAR1 = 32'h6ED9EBA1;
    localparam word_t K_MAJ  = 32'h8F1BBCDC;
    localparam word_t K_PAR2 = 32'hCA62C1D6;

    // Running hash state of the message in flight
    chain_t      hash_state;
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_len;

    // Digests owed by the block, oldest first
    chain_t      digests_due [$];

    chain_t      got_digest;
    chain_t      want_digest;

    // One 80-round compression of block_bytes into hash_state
    function automatic void compress_block();
        word_t w [16];
        word_t a, b, c, d, e, f, k, tmp;
        for (int t = 0; t < 16; t++)
        begin
            w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                    block_bytes[4*t+3]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int t = 0; t < 80; t++)
        begin
            // rolling schedule: overwrite the slot that is 16 rounds old
            if (t >= 16)
            begin
                tmp = w[(t + 13) & 15] ^ w[(t + 8) & 15] ^ w[(t + 2) & 15] ^ w[t & 15];
                w[t & 15] = {tmp[30:0], tmp[31]};
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = K_CH;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = K_PAR1;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = K_PAR2;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w[t & 15];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        hash_state[4] = hash_state[4] + e;
    endfunction

    // Absorb one accepted input transfer; on end of message queue the digest
    function automatic void absorb_item(input logic [7:0] data, input logic has,
                                        input logic last);
        int          pos;
        logic [63:0] bit_len;
        if (has)
        begin
            block_bytes[msg_len[5:0]] = data;
            msg_len = msg_len + 61'd1;
            if (msg_len[5:0] == 6'd0)
                compress_block();
        end
        if (last)
        begin
            pos = int'(msg_len[5:0]);
            block_bytes[pos] = PAD_MARK;
            pos++;
            // no room for the length: pad out and compress an extra block
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    block_bytes[pos] = 8'h00;
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < 56)
            begin
                block_bytes[pos] = 8'h00;
                pos++;
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = bit_len[63 - 8*i -: 8];
            compress_block();
            digests_due = {digests_due, hash_state};
            hash_state = CHAIN_INIT;
            msg_len = '0;
        end
    endfunction

    // Monitor both channels on every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_state = CHAIN_INIT;
            msg_len = '0;
            digests_due.delete();
            pending <= 0;
        end
        else
        begin
            if (msg.valid && msg.ready)
                absorb_item(msg.data_byte, msg.has_byte, msg.is_last);
            if (digest.valid && digest.ready)
            begin
                got_digest = {digest.digest_word4, digest.digest_word3,
                              digest.digest_word2, digest.digest_word1,
                              digest.digest_word0};
                if (digests_due.size() == 0)
                begin
                    $error("digest transfer with none expected: %040h", got_digest);
                    errors++;
                end
                else
                begin
                    want_digest = digests_due.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (got_digest[i] !== want_digest[i])
                        begin
                            $error("digest_word%0d: expected %08h, actual %08h",
                                   i, want_digest[i], got_digest[i]);
                            errors++;
                        end
                    end
                end
            end
            pending <= digests_due.size();
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the SHA-1 stream hasher testbench: clock, reset, message stimulus,
// digest back-pressure and the verdict. Depends on sha1_pkg, sha1_if.sv,
// sha1_stream_hasher and sha1_digest_checker.

module testbench;

    localparam int BYTE_BUDGET = 1500;

    logic clk;
    logic rst_n;

    int   n_errors;
    int   n_pending;
    int   gap_pct;
    int   stall_pct;
    int   bytes_sent;
    int   phase;
    int   next_phase;
    int   msg_bytes;
    int   pick;

    sha1_byte_if   msg_ch ();
    sha1_digest_if dig_ch ();

    sha1_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    sha1_digest_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .digest  (dig_ch),
        .errors  (n_errors),
        .pending (n_pending)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    // Digest back-pressure
    initial
    begin
        dig_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            dig_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // One input transfer, after random gap cycles
    task automatic send_item(input logic [7:0] data, input logic has, input logic last);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.data_byte <= data;
        msg_ch.has_byte  <= has;
        msg_ch.is_last   <= last;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending until every owed digest has come back
    task automatic drain();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    // A message of random bytes, with idle transfers mixed in; ends either on
    // the final byte or on a bare end marker
    task automatic send_message(input int len);
        logic on_byte;
        on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, on_byte && (i == len - 1));
        end
        if (!on_byte)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Stimulus
    initial
    begin
        gap_pct = 0;
        stall_pct = 0;
        msg_ch.valid     <= 1'b0;
        msg_ch.data_byte <= 8'h00;
        msg_ch.has_byte  <= 1'b0;
        msg_ch.is_last   <= 1'b0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message
        send_item(8'hFF, 1'b0, 1'b1);
        // idle transfer, then a lone zero byte together with the end
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
        // bytes, an idle transfer, then a bare end marker carrying junk data
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hAA, 1'b1, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h81, 1'b0, 1'b1);
        // "abc"
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        // two empty messages back to back, then a one-byte message
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h7F, 1'b0, 1'b1);
        send_item(8'h55, 1'b1, 1'b1);

        // Random messages over four idling phases
        bytes_sent = 0;
        phase = 0;
        while (bytes_sent < BYTE_BUDGET)
        begin
            next_phase = bytes_sent * 4 / BYTE_BUDGET;
            if (next_phase != phase)
            begin
                phase = next_phase;
                drain();
                case (phase)
                    1:
                    begin
                        gap_pct = 46;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        gap_pct = 0;
                        stall_pct = 46;
                    end
                    default:
                    begin
                        gap_pct = 25;
                        stall_pct = 25;
                    end
                endcase
            end
            pick = $urandom_range(0, 9);
            case (pick)
                0:       msg_bytes = 0;
                1:       msg_bytes = ($urandom_range(0, 1) == 1) ?
                                     $urandom_range(55, 57) : $urandom_range(63, 65);
                2:       msg_bytes = $urandom_range(118, 121);
                3:       msg_bytes = $urandom_range(66, 140);
                default: msg_bytes = $urandom_range(1, 50);
            endcase
            send_message(msg_bytes);
            bytes_sent += msg_bytes;
        end

        // Wind down
        drain();
        repeat (250) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sha1_stream_hasher.f @@
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_dp.sv
rtl/sha1_ctrl.sv
rtl/sha1_stream_hasher.sv
tb/sv/sha1_digest_checker.sv
tb/sv/testbench.sv
